// ===== hdl/pcxd_pkg.sv =====
// Shared types and constants for the PCX run-length palette decoder.
package pcxd_pkg;

  localparam int unsigned MAX_PIXELS_DEF = 65536;

  // Header layout
  localparam logic [6:0] HDR_MAKER     = 7'd0;
  localparam logic [6:0] HDR_XMIN_LO   = 7'd4;
  localparam logic [6:0] HDR_XMIN_HI   = 7'd5;
  localparam logic [6:0] HDR_YMIN_LO   = 7'd6;
  localparam logic [6:0] HDR_YMIN_HI   = 7'd7;
  localparam logic [6:0] HDR_XMAX_LO   = 7'd8;
  localparam logic [6:0] HDR_XMAX_HI   = 7'd9;
  localparam logic [6:0] HDR_YMAX_LO   = 7'd10;
  localparam logic [6:0] HDR_YMAX_HI   = 7'd11;
  localparam logic [6:0] HDR_LAST      = 7'd127;
  localparam logic [7:0] MAKER_BYTE    = 8'd10;

  // Run-length coding
  localparam logic [1:0] RUN_MARK      = 2'b11;

  // Palette: 256 entries of packed 4-bit red, green, blue
  localparam int unsigned PAL_DEPTH    = 256;
  localparam int unsigned PAL_W        = 12;
  localparam logic [7:0] PAL_LAST_ENT  = 8'd255;
  localparam logic [1:0] PAL_COMP_R    = 2'd0;
  localparam logic [1:0] PAL_COMP_G    = 2'd1;
  localparam logic [1:0] PAL_COMP_B    = 2'd2;

  typedef enum logic [2:0] {
    STAT_PIXEL     = 3'd0,
    STAT_BAD_MAKER = 3'd1,
    STAT_NOT_READY = 3'd2,
    STAT_BAD_SIZE  = 3'd3,
    STAT_NO_PIXEL  = 3'd4
  } pcxd_status_e;

  // Controller to datapath
  typedef struct packed {
    logic         restart;
    logic         hdr_byte;
    logic         span_calc;
    logic         prod_calc;
    logic         total_load;
    logic         set_run;
    logic         run_start;
    logic         run_step;
    logic         lit_write;
    logic         pal_byte;
    logic         idx_read;
    logic         pal_read;
    logic         out_load;
    pcxd_status_e out_status;
  } pcxd_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic hdr_last;
    logic maker_ok;
    logic span_bad;
    logic size_bad;
    logic run_pending;
    logic byte_is_run;
    logic lit_last;
    logic run_done;
    logic run_full;
    logic pal_last;
    logic pix_left;
    logic out_free;
  } pcxd_stat_t;

endpackage

// ===== hdl/pcxd_ram.sv =====
// Generic simple dual-port RAM with registered read.
module pcxd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/pcxd_dp.sv =====
// Datapath: header fields, size arithmetic, counters, index and palette stores, output word.
module pcxd_dp #(
  parameter int unsigned MAX_PIXELS = pcxd_pkg::MAX_PIXELS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [7:0]          data_i,
  input  pcxd_pkg::pcxd_cmd_t cmd_i,
  output pcxd_pkg::pcxd_stat_t stat_o,
  input  logic                m_tready_i,
  output logic                m_tvalid_o,
  output logic [15:0]         m_tdata_o,
  output logic [2:0]          m_tuser_o,
  output logic                m_tlast_o
);

  import pcxd_pkg::*;

  localparam int unsigned CNT_W  = $clog2(MAX_PIXELS + 1);
  localparam int unsigned ADDR_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

  logic [6:0]        hdr_cnt_q, hc;
  logic              maker_ok_q;
  logic [15:0]       x_low_q, y_low_q, x_high_q, y_high_q;
  logic signed [17:0] xs, ys, xs_q, ys_q;
  logic              span_bad_q;
  logic [33:0]       prod, prod_q;
  logic [CNT_W-1:0]  total_q, wc_q, rc_q, wc_inc, rc_inc;
  logic              run_pend_q;
  logic [5:0]        run_len_q, run_left_q;
  logic [7:0]        run_val_q;
  logic [7:0]        pal_ent_q;
  logic [1:0]        pal_comp_q;
  logic [3:0]        pal_r_q, pal_g_q;
  logic              out_valid_q, out_last_q;
  logic [15:0]       out_color_q;
  pcxd_status_e      out_status_q;
  logic              pixel_load;
  logic              idx_we, pal_we;
  logic [7:0]        idx_wdata, idx_rdata;
  logic [PAL_W-1:0]  pal_rdata;

  assign hc         = cmd_i.restart ? HDR_MAKER : hdr_cnt_q;
  assign xs         = $signed({x_high_q[15], x_high_q}) - $signed({x_low_q[15], x_low_q})
                      + 18'sd1;
  assign ys         = $signed({y_high_q[15], y_high_q}) - $signed({y_low_q[15], y_low_q})
                      + 18'sd1;
  assign prod       = xs_q[16:0] * ys_q[16:0];
  assign wc_inc     = wc_q + CNT_W'(1);
  assign rc_inc     = rc_q + CNT_W'(1);
  assign pixel_load = cmd_i.out_load && (cmd_i.out_status == STAT_PIXEL);

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_cnt_q   <= '0;
      maker_ok_q  <= 1'b0;
      span_bad_q  <= 1'b0;
      total_q     <= '0;
      wc_q        <= '0;
      rc_q        <= '0;
      run_pend_q  <= 1'b0;
      run_len_q   <= '0;
      run_left_q  <= '0;
      pal_ent_q   <= '0;
      pal_comp_q  <= PAL_COMP_R;
      out_valid_q <= 1'b0;
    end else begin
      // a restart always comes with header byte 0, which rewrites maker_ok
      if (cmd_i.restart) begin
        total_q    <= '0;
        wc_q       <= '0;
        rc_q       <= '0;
        run_pend_q <= 1'b0;
        run_len_q  <= '0;
        pal_ent_q  <= '0;
        pal_comp_q <= PAL_COMP_R;
      end
      if (cmd_i.hdr_byte) begin
        hdr_cnt_q <= hc + 7'd1;
        if (hc == HDR_MAKER) begin
          maker_ok_q <= (data_i == MAKER_BYTE);
        end
      end
      if (cmd_i.span_calc) begin
        span_bad_q <= (xs <= 18'sd0) || (ys <= 18'sd0);
      end
      if (cmd_i.total_load) begin
        total_q <= prod_q[CNT_W-1:0];
      end
      if (cmd_i.set_run) begin
        run_pend_q <= 1'b1;
        run_len_q  <= data_i[5:0];
      end
      if (cmd_i.run_start) begin
        run_pend_q <= 1'b0;
        run_left_q <= run_len_q;
      end
      if (cmd_i.run_step) begin
        run_left_q <= run_left_q - 6'd1;
        wc_q       <= wc_inc;
      end
      if (cmd_i.lit_write) begin
        wc_q <= wc_inc;
      end
      if (cmd_i.pal_byte) begin
        if (pal_comp_q == PAL_COMP_B) begin
          pal_comp_q <= PAL_COMP_R;
          pal_ent_q  <= pal_ent_q + 8'd1;
        end else begin
          pal_comp_q <= pal_comp_q + 2'd1;
        end
      end
      if (pixel_load) begin
        rc_q <= rc_inc;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.restart) begin
      x_low_q  <= '0;
      y_low_q  <= '0;
      x_high_q <= '0;
      y_high_q <= '0;
    end
    if (cmd_i.hdr_byte) begin
      case (hc)
        HDR_XMIN_LO: x_low_q[7:0]   <= data_i;
        HDR_XMIN_HI: x_low_q[15:8]  <= data_i;
        HDR_YMIN_LO: y_low_q[7:0]   <= data_i;
        HDR_YMIN_HI: y_low_q[15:8]  <= data_i;
        HDR_XMAX_LO: x_high_q[7:0]  <= data_i;
        HDR_XMAX_HI: x_high_q[15:8] <= data_i;
        HDR_YMAX_LO: y_high_q[7:0]  <= data_i;
        HDR_YMAX_HI: y_high_q[15:8] <= data_i;
        default: ;
      endcase
    end
    if (cmd_i.span_calc) begin
      xs_q <= xs;
      ys_q <= ys;
    end
    if (cmd_i.prod_calc) begin
      prod_q <= prod;
    end
    if (cmd_i.run_start) begin
      run_val_q <= data_i;
    end
    if (cmd_i.pal_byte) begin
      if (pal_comp_q == PAL_COMP_R) begin
        pal_r_q <= data_i[7:4];
      end
      if (pal_comp_q == PAL_COMP_G) begin
        pal_g_q <= data_i[7:4];
      end
    end
    if (cmd_i.out_load) begin
      out_status_q <= cmd_i.out_status;
      if (pixel_load) begin
        out_color_q <= {pal_rdata[11:8], 1'b0, pal_rdata[7:4], 2'b00, pal_rdata[3:0], 1'b0};
        out_last_q  <= (rc_inc == total_q);
      end else begin
        out_color_q <= '0;
        out_last_q  <= 1'b0;
      end
    end
  end

  assign idx_we    = cmd_i.lit_write || cmd_i.run_step;
  assign idx_wdata = cmd_i.run_step ? run_val_q : data_i;
  assign pal_we    = cmd_i.pal_byte && (pal_comp_q == PAL_COMP_B);

  pcxd_ram #(
    .WIDTH(8),
    .DEPTH(MAX_PIXELS)
  ) u_idx_ram (
    .clk_i  (clk_i),
    .we_i   (idx_we),
    .waddr_i(wc_q[ADDR_W-1:0]),
    .wdata_i(idx_wdata),
    .re_i   (cmd_i.idx_read),
    .raddr_i(rc_q[ADDR_W-1:0]),
    .rdata_o(idx_rdata)
  );

  pcxd_ram #(
    .WIDTH(PAL_W),
    .DEPTH(PAL_DEPTH)
  ) u_pal_ram (
    .clk_i  (clk_i),
    .we_i   (pal_we),
    .waddr_i(pal_ent_q),
    .wdata_i({pal_r_q, pal_g_q, data_i[7:4]}),
    .re_i   (cmd_i.pal_read),
    .raddr_i(idx_rdata),
    .rdata_o(pal_rdata)
  );

  always_comb begin
    stat_o             = '0;
    stat_o.hdr_last    = (hc == HDR_LAST);
    stat_o.maker_ok    = maker_ok_q;
    stat_o.span_bad    = span_bad_q;
    stat_o.size_bad    = (prod_q > 34'(MAX_PIXELS));
    stat_o.run_pending = run_pend_q;
    stat_o.byte_is_run = (data_i[7:6] == RUN_MARK);
    stat_o.lit_last    = (wc_inc == total_q);
    stat_o.run_full    = (wc_q == total_q);
    stat_o.run_done    = (run_left_q == 6'd0) || (wc_q == total_q);
    stat_o.pal_last    = (pal_comp_q == PAL_COMP_B) && (pal_ent_q == PAL_LAST_ENT);
    stat_o.pix_left    = (rc_q != total_q);
    stat_o.out_free    = !out_valid_q || m_tready_i;
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_color_q;
  assign m_tuser_o  = out_status_q;
  assign m_tlast_o  = out_last_q;

endmodule

// ===== hdl/pcxd_ctrl.sv =====
// Controller: decode phase state machine and command sequencing.
module pcxd_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_tvalid_i,
  input  logic                 func_i,
  input  logic                 sof_i,
  output logic                 s_tready_o,
  input  pcxd_pkg::pcxd_stat_t stat_i,
  output pcxd_pkg::pcxd_cmd_t  cmd_o
);

  import pcxd_pkg::*;

  typedef enum logic [3:0] {
    ST_HEADER,
    ST_SPAN,
    ST_MUL,
    ST_CHECK,
    ST_DATA,
    ST_RUN,
    ST_SKIP,
    ST_PALETTE,
    ST_READY,
    ST_BADMAKER,
    ST_BADSIZE,
    ST_PULL_IDX,
    ST_PULL_PAL
  } state_e;

  state_e state_q, state_d;
  logic   accepting, accept;

  always_comb begin
    case (state_q)
      ST_HEADER, ST_DATA, ST_SKIP, ST_PALETTE,
      ST_READY, ST_BADMAKER, ST_BADSIZE: accepting = 1'b1;
      default:                           accepting = 1'b0;
    endcase
  end

  assign s_tready_o = accepting && stat_i.out_free;
  assign accept     = s_tvalid_i && s_tready_o;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    if (accept) begin
      if (!func_i) begin
        if (sof_i) begin
          cmd_o.restart  = 1'b1;
          cmd_o.hdr_byte = 1'b1;
          state_d        = ST_HEADER;
        end else begin
          case (state_q)
            ST_HEADER: begin
              cmd_o.hdr_byte = 1'b1;
              if (stat_i.hdr_last) state_d = ST_SPAN;
            end
            ST_DATA: begin
              if (stat_i.run_pending) begin
                cmd_o.run_start = 1'b1;
                state_d         = ST_RUN;
              end else if (stat_i.byte_is_run) begin
                cmd_o.set_run = 1'b1;
              end else begin
                cmd_o.lit_write = 1'b1;
                if (stat_i.lit_last) state_d = ST_SKIP;
              end
            end
            ST_SKIP: state_d = ST_PALETTE;
            ST_PALETTE: begin
              cmd_o.pal_byte = 1'b1;
              if (stat_i.pal_last) state_d = ST_READY;
            end
            default: ;
          endcase
        end
      end else if (state_q == ST_READY && stat_i.pix_left) begin
        cmd_o.idx_read = 1'b1;
        state_d        = ST_PULL_IDX;
      end else begin
        cmd_o.out_load = 1'b1;
        case (state_q)
          ST_BADMAKER: cmd_o.out_status = STAT_BAD_MAKER;
          ST_BADSIZE:  cmd_o.out_status = STAT_BAD_SIZE;
          ST_READY:    cmd_o.out_status = STAT_NO_PIXEL;
          default:     cmd_o.out_status = STAT_NOT_READY;
        endcase
      end
    end else begin
      case (state_q)
        ST_SPAN: begin
          if (!stat_i.maker_ok) begin
            state_d = ST_BADMAKER;
          end else begin
            cmd_o.span_calc = 1'b1;
            state_d         = ST_MUL;
          end
        end
        ST_MUL: begin
          if (stat_i.span_bad) begin
            state_d = ST_BADSIZE;
          end else begin
            cmd_o.prod_calc = 1'b1;
            state_d         = ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (stat_i.size_bad) begin
            state_d = ST_BADSIZE;
          end else begin
            cmd_o.total_load = 1'b1;
            state_d          = ST_DATA;
          end
        end
        ST_RUN: begin
          if (stat_i.run_done) begin
            state_d = stat_i.run_full ? ST_SKIP : ST_DATA;
          end else begin
            cmd_o.run_step = 1'b1;
          end
        end
        ST_PULL_IDX: begin
          cmd_o.pal_read = 1'b1;
          state_d        = ST_PULL_PAL;
        end
        ST_PULL_PAL: begin
          if (stat_i.out_free) begin
            cmd_o.out_load   = 1'b1;
            cmd_o.out_status = STAT_PIXEL;
            state_d          = ST_READY;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_HEADER;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hdl/pcx_rle_palette_decoder.sv =====
// Top level of the PCX run-length decoder with 8-bit palette lookup.
// Feed the file as words with tuser[0] = 0, one byte in tdata; tuser[1] set on
// a byte marks header byte 0 of a new file and restarts decoding. The 128-byte
// header must carry maker byte 10; Xmin, Ymin, Xmax, Ymax (bytes 4..11, signed
// little-endian) set the pixel count. Image bytes are run-length decoded into
// the index store (one index per cycle), one byte is skipped, then 768
// palette bytes are taken. A word with tuser[0] = 1 pulls the next pixel and
// yields one output word: tdata = red<<12 | green<<7 | blue<<1 (4-bit
// components), tuser = status (0 pixel, 1 bad maker, 2 not ready, 3 bad size,
// 4 no pixel left), tlast on the final pixel. Byte words give no output.
// An ordinary byte or an error/status pull is handled in its accepting cycle. A
// run value byte holds off input for all but its accepting cycle while the index
// store is written one entry per cycle, min(length, indices missing) entries in
// all. The last header byte is followed by busy steps (span subtract, 17x17
// multiply, range check); a bad maker byte ends them at the first, a span that
// is not positive at the second. A pixel pull goes through index store read,
// palette store read and output register. Input is also held while the output
// word waits.
// No clearing pass is needed after reset; stores are only read where written.
module pcx_rle_palette_decoder #(
  parameter int unsigned MAX_PIXELS = pcxd_pkg::MAX_PIXELS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic [1:0]  s_axis_tuser_i,   // [0] func, [1] start_of_file
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [15:0] pixel_color
  output logic [2:0]  m_axis_tuser_o,   // [2:0] status
  output logic        m_axis_tlast_o    // last_pixel
);

  import pcxd_pkg::*;

  pcxd_cmd_t  cmd;
  pcxd_stat_t stat;

  // Phase sequencing and handshake
  pcxd_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_axis_tvalid_i),
    .func_i    (s_axis_tuser_i[0]),
    .sof_i     (s_axis_tuser_i[1]),
    .s_tready_o(s_axis_tready_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  // Header, counters, stores and output word
  pcxd_dp #(
    .MAX_PIXELS(MAX_PIXELS)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .data_i    (s_axis_tdata_i),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .m_tready_i(m_axis_tready_i),
    .m_tvalid_o(m_axis_tvalid_o),
    .m_tdata_o (m_axis_tdata_o),
    .m_tuser_o (m_axis_tuser_o),
    .m_tlast_o (m_axis_tlast_o)
  );

  // An input word is only taken when the output register has room
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |-> !m_axis_tvalid_o || m_axis_tready_i)
    else $error("input taken while output word blocked");

  // Only a real pixel may carry the end-of-image mark
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> m_axis_tuser_o == STAT_PIXEL)
    else $error("tlast on a status word");

  // Status words carry no colour
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o != STAT_PIXEL |-> m_axis_tdata_o == 16'd0)
    else $error("status word with non-zero colour");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the PCX run-length palette decoder.
module testbench;
  import pcxd_pkg::*;

  localparam int unsigned MAX_PIX        = MAX_PIXELS_DEF;
  localparam bit          FUNC_BYTE      = 1'b0;
  localparam bit          FUNC_PULL      = 1'b1;
  localparam logic [7:0]  RUN_FLAG       = 8'hC0;   // both top bits set: run marker
  localparam logic [7:0]  RUN_LEN_MASK   = 8'h3F;
  localparam logic [7:0]  LIT_MAX        = 8'hBF;   // largest byte that is still a literal
  localparam int          HDR_BYTES      = 128;
  localparam int          PAL_BYTES      = 768;
  localparam int          GAP_MAX        = 19;      // upper bound of the random idle gap drawn per word
  localparam int          LONG_HOLD      = 400;     // length of the receiver back-pressure stretch
  localparam int          TAIL_CYCLES    = 100;     // covers a 63-long run plus header busy
  localparam int          LIMIT_NS       = 5_000_000;

  typedef enum logic [2:0] {
    IMG_HEADER,
    IMG_DATA,
    IMG_SKIP,
    IMG_PALETTE,
    IMG_READY,
    IMG_BAD_MAKER,
    IMG_BAD_SIZE
  } img_phase_e;

  typedef struct packed {
    logic [15:0]  color;
    pcxd_status_e status;
    logic         last;
  } pixel_word_t;

  // Tracks the decoder's view of the file and keeps the pixel words still owed.
  class pcx_image_tracker;
    img_phase_e  phase;
    int unsigned hdr_seen, pixel_total, write_count, read_count, pal_count;
    bit          maker_ok, run_armed;
    logic [5:0]  run_len;
    logic [15:0] x_lo, y_lo, x_hi, y_hi;
    logic [3:0]  pal_nib [PAL_BYTES];
    logic [7:0]  index_mem [MAX_PIX];
    pixel_word_t awaited_pixels[$];
    int          errors;

    function new();
      restart();
      errors = 0;
    endfunction

    function void restart();
      phase       = IMG_HEADER;
      hdr_seen    = 0;
      maker_ok    = 1'b0;
      x_lo        = '0;
      y_lo        = '0;
      x_hi        = '0;
      y_hi        = '0;
      pixel_total = 0;
      write_count = 0;
      run_armed   = 1'b0;
      run_len     = '0;
      pal_count   = 0;
      read_count  = 0;
    endfunction

    // Signed spans; a bad maker byte, empty or oversized images are parked in an error phase.
    function void close_header();
      shortint sx0, sy0, sx1, sy1;
      int      xs, ys;
      longint  area;
      if (!maker_ok) begin
        phase = IMG_BAD_MAKER;
        return;
      end
      sx0 = x_lo;
      sy0 = y_lo;
      sx1 = x_hi;
      sy1 = y_hi;
      xs  = int'(sx1) - int'(sx0) + 1;
      ys  = int'(sy1) - int'(sy0) + 1;
      if (xs <= 0 || ys <= 0) begin
        phase = IMG_BAD_SIZE;
        return;
      end
      area = longint'(xs) * longint'(ys);
      if (area > longint'(MAX_PIX)) begin
        phase = IMG_BAD_SIZE;
        return;
      end
      pixel_total = int'(area);
      phase       = IMG_DATA;
    endfunction

    // A run is clamped to the indices still missing.
    function void store_indices(logic [7:0] value, int unsigned count);
      int unsigned n;
      n = (count > pixel_total - write_count) ? pixel_total - write_count : count;
      repeat (n) begin
        index_mem[write_count] = value;
        write_count++;
      end
      if (write_count >= pixel_total) phase = IMG_SKIP;
    endfunction

    function void take_byte(logic [7:0] b, bit sof);
      if (sof) restart();
      case (phase)
        IMG_HEADER: begin
          case (hdr_seen)
            HDR_MAKER:   maker_ok = (b == MAKER_BYTE);
            HDR_XMIN_LO: x_lo[7:0] = b;
            HDR_XMIN_HI: x_lo[15:8] = b;
            HDR_YMIN_LO: y_lo[7:0] = b;
            HDR_YMIN_HI: y_lo[15:8] = b;
            HDR_XMAX_LO: x_hi[7:0] = b;
            HDR_XMAX_HI: x_hi[15:8] = b;
            HDR_YMAX_LO: y_hi[7:0] = b;
            HDR_YMAX_HI: y_hi[15:8] = b;
            default: ;
          endcase
          hdr_seen++;
          if (hdr_seen >= HDR_BYTES) close_header();
        end
        IMG_DATA: begin
          if (run_armed) begin
            run_armed = 1'b0;
            store_indices(b, run_len);
          end else if ((b & RUN_FLAG) == RUN_FLAG) begin
            run_armed = 1'b1;
            run_len   = 6'(b & RUN_LEN_MASK);
          end else begin
            store_indices(b, 1);
          end
        end
        IMG_SKIP: phase = IMG_PALETTE;
        IMG_PALETTE: begin
          pal_nib[pal_count] = b[7:4];
          pal_count++;
          if (pal_count >= PAL_BYTES) phase = IMG_READY;
        end
        default: ;  // error phases and a finished image ignore bytes
      endcase
    endfunction

    function void note_word(bit func, logic [7:0] b, bit sof);
      pixel_word_t w;
      int unsigned base;
      if (func == FUNC_BYTE) begin
        take_byte(b, sof);
        return;
      end
      w        = '0;
      w.status = STAT_PIXEL;
      case (phase)
        IMG_BAD_MAKER: w.status = STAT_BAD_MAKER;
        IMG_BAD_SIZE:  w.status = STAT_BAD_SIZE;
        IMG_READY: begin
          if (read_count >= pixel_total) begin
            w.status = STAT_NO_PIXEL;
          end else begin
            base    = 32'(index_mem[read_count]) * 3;
            w.color = {pal_nib[base], 1'b0, pal_nib[base + 1], 2'b00, pal_nib[base + 2], 1'b0};
            read_count++;
            w.last  = (read_count == pixel_total);
          end
        end
        default: w.status = STAT_NOT_READY;
      endcase
      awaited_pixels.push_back(w);
    endfunction

    function void check_word(logic [15:0] color, logic [2:0] status, logic last);
      pixel_word_t w;
      if (awaited_pixels.size() == 0) begin
        $error("output word with nothing awaited: pixel_color %h status %0d last_pixel %b",
               color, status, last);
        errors++;
        return;
      end
      w = awaited_pixels.pop_front();
      if (color !== w.color) begin
        $error("pixel_color: expected %h, got %h", w.color, color);
        errors++;
      end
      if (status !== w.status) begin
        $error("status: expected %0d, got %0d", w.status, status);
        errors++;
      end
      if (last !== w.last) begin
        $error("last_pixel: expected %b, got %b", w.last, last);
        errors++;
      end
    endfunction

    function int outstanding();
      return awaited_pixels.size();
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;    // [7:0] data_byte
  logic [1:0]  s_axis_tuser  = '0;    // [0] func, [1] start_of_file
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;          // [15:0] pixel_color
  logic [2:0]  m_axis_tuser;          // [2:0] status
  logic        m_axis_tlast;          // last_pixel

  // Idle limits per side; 0 gives back-to-back stretches.
  int src_gap_max   = GAP_MAX;
  int snk_gap_max   = GAP_MAX;
  bit hold_request  = 1'b0;

  pcx_image_tracker tracker;

  always #4 clk_i = ~clk_i;

  pcx_rle_palette_decoder uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser),
    .m_axis_tlast_o  (m_axis_tlast)
  );

  // tvalid stays high across back-to-back words; only one assignment per step.
  task automatic send_word(input bit func, input logic [7:0] b, input bit sof);
    int gap;
    gap = $urandom_range(0, src_gap_max);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= {sof, func};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    tracker.note_word(func, b, sof);
  endtask

  // Pulls carry random data and start marks, both of which the block ignores.
  task automatic pull_word();
    send_word(FUNC_PULL, 8'($urandom), 1'($urandom));
  endtask

  task automatic file_byte(input logic [7:0] b, input bit sof = 1'b0);
    send_word(FUNC_BYTE, b, sof);
  endtask

  task automatic send_header(input logic [7:0] maker, input logic [15:0] x0, y0, x1, y1,
                             input bit mark);
    logic [7:0] b;
    for (int i = 0; i < HDR_BYTES; i++) begin
      case (i)
        HDR_MAKER:   b = maker;
        HDR_XMIN_LO: b = x0[7:0];
        HDR_XMIN_HI: b = x0[15:8];
        HDR_YMIN_LO: b = y0[7:0];
        HDR_YMIN_HI: b = y0[15:8];
        HDR_XMAX_LO: b = x1[7:0];
        HDR_XMAX_HI: b = x1[15:8];
        HDR_YMAX_LO: b = y1[7:0];
        HDR_YMAX_HI: b = y1[15:8];
        default:     b = 8'($urandom);
      endcase
      file_byte(b, mark && i == 0);
      if (i > 0 && $urandom_range(0, 63) == 0) pull_word();
    end
  endtask

  task automatic send_palette();
    file_byte(8'($urandom));  // the one skipped byte
    for (int i = 0; i < PAL_BYTES; i++) begin
      file_byte(8'($urandom));
      if ($urandom_range(0, 255) == 0) pull_word();
    end
  endtask

  task automatic send_bad_file(input logic [7:0] maker, input logic [15:0] x0, y0, x1, y1);
    send_header(maker, x0, y0, x1, y1, 1'b1);
    repeat ($urandom_range(0, 4)) file_byte(8'($urandom));
    repeat ($urandom_range(1, 3)) pull_word();
  endtask

  // Result side: random stalls, plus one long hold-off once a word is waiting.
  initial begin
    int gap;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        m_axis_tready <= 1'b0;
        @(posedge clk_i);
        while (!m_axis_tvalid) @(posedge clk_i);
        repeat (LONG_HOLD) @(posedge clk_i);
      end else begin
        gap = $urandom_range(0, snk_gap_max);
        if (gap > 0) begin
          m_axis_tready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      tracker.check_word(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end
  end

  initial begin
    tracker = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: pull straight after reset, then a 16 x 1 file with no start mark
    // (taken as header from reset) at the most negative/positive coordinates.
    pull_word();
    send_header(MAKER_BYTE, 16'h8000, 16'h7FFF, 16'h800F, 16'h7FFF, 1'b0);
    file_byte(8'h00);                 // smallest literal
    file_byte(LIT_MAX);               // largest literal
    file_byte(RUN_FLAG);              // zero-length run ...
    file_byte(8'hFF);                 // ... whose value is eaten
    file_byte(RUN_FLAG | 8'd3);
    file_byte(8'h7E);
    file_byte(8'h41);
    file_byte(RUN_FLAG | 8'd4);
    file_byte(8'hC9);                 // run value that looks like a run marker
    file_byte(8'h12);
    file_byte(8'h34);
    file_byte(8'h56);
    file_byte(8'h9A);
    file_byte(8'hAB);
    file_byte(RUN_FLAG | RUN_LEN_MASK);
    file_byte(8'hC5);                 // 63-long run clamped to the one index left
    pull_word();                      // palette not in yet
    send_palette();

    // Back-pressure: output held off while pulls keep coming.
    src_gap_max  = 0;
    snk_gap_max  = 0;
    hold_request = 1'b1;
    repeat (17) pull_word();          // sixteen pixels, then none left
    file_byte(8'hFF);                 // ignored after the palette
    pull_word();
    src_gap_max  = GAP_MAX;
    snk_gap_max  = GAP_MAX;

    // Broken files: bad maker byte, then one of the bad sizes.
    send_bad_file(8'hF5, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    case ($urandom_range(0, 3))
      0:       send_bad_file(MAKER_BYTE, 16'h7FFF, 16'h0000, 16'h8000, 16'h0000);  // negative
      1:       send_bad_file(MAKER_BYTE, 16'h0000, 16'h0010, 16'h0000, 16'h000F);  // zero span
      2:       send_bad_file(MAKER_BYTE, 16'h8000, 16'h0000, 16'h7FFF, 16'h0001);  // twice the limit
      default: send_bad_file(MAKER_BYTE, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF);  // 2^32
    endcase

    s_axis_tvalid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
